@@ rtl/multi_queue_shared_array_top_assert.svh @@
// Assertion macros shared by the queue store RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTI_QUEUE_SHARED_ARRAY_TOP_ASSERT_SVH
`define MULTI_QUEUE_SHARED_ARRAY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MQSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MQSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mqsa_pkg.sv @@
// Shared constants, codes and controller/datapath interface structs
// for the shared-store queue block. No dependencies.
package mqsa_pkg;

   localparam int ARRAY_SIZE_DEF = 64;
   localparam int MAX_QUEUES_DEF = 8;

   localparam int DATA_W      = 32;
   localparam int REQ_W       = 2;
   localparam int QID_W       = 4;
   localparam int CNT_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int REQ_TUSER_W = REQ_W + QID_W;
   localparam int RSP_TUSER_W = STATUS_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_QUEUE_COUNT = 3'd0;
   localparam logic [CNT_W-1:0] QUEUE_COUNT_RESET = 4'd3;

   typedef enum logic [REQ_W-1:0] {
      REQ_ENQ  = 2'd0,
      REQ_DEQ  = 2'd1,
      REQ_PEEK = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_OVER  = 2'd1,
      ST_UNDER = 2'd2,
      ST_BADQ  = 2'd3
   } status_type;

   typedef struct packed {
      logic       latch_req;
      logic       part_start;
      logic       part_step;
      logic       rd_q;
      logic       rd_n1;
      logic       rd_n2;
      logic       deq_upd;
      logic       ram_rd_head;
      logic       enq_simple;
      logic       shift_init;
      logic       shift_step;
      logic       borrow_upd1;
      logic       borrow_upd2;
      logic       res_clear;
      logic       res_set;
      status_type res_code;
      logic       cap_data;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic ignored;
      logic bad_q;
      logic is_enq;
      logic empty;
      logic full;
      logic can_borrow;
      logic shift_done;
      logic part_done;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/multi_queue_shared_array_top.sv @@
// Top level of the shared-store multi-queue block: register port, controller and datapath.
// Depends on mqsa_pkg, mqsa_ctrl, mqsa_dp and mqsa_ram.
//
//   channel | direction | handshake                  | payload
//   req     | in        | req_tvalid / req_tready    | tdata data_in; tuser req_type, queue_id
//   rsp     | out       | rsp_tvalid / rsp_tready    | tdata data_out; tuser status, data_valid
//   csr     | in        | psel, penable, pwrite      | queue_count at byte address 0
//
// One item is handled at a time. An ignored or bad request goes from the check straight
// to its result; an underflow first reads the queue's bounds; a dequeue or peek that
// returns a word then also reads the word store; an enqueue also reads the next queue's
// bounds, and a borrowing enqueue then shifts the next queue's live words up one slot;
// the shift moves one word per cycle through the word store's single read port.
// After reset and after each write of queue_count, the bounds are rebuilt one queue per
// cycle; no item is accepted until that is done.
// A result left waiting on rsp does not hold off the next acceptance, but that next item
// then waits in its last cycle until the earlier result has been taken.
module multi_queue_shared_array_top #(
   parameter int ARRAY_SIZE = mqsa_pkg::ARRAY_SIZE_DEF,
   parameter int MAX_QUEUES = mqsa_pkg::MAX_QUEUES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mqsa_pkg::DATA_W-1:0]         req_tdata,   // [31:0] data_in
   input  logic [mqsa_pkg::REQ_TUSER_W-1:0]    req_tuser,   // [1:0] req_type, [5:2] queue_id
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mqsa_pkg::DATA_W-1:0]         rsp_tdata,   // [31:0] data_out
   output logic [mqsa_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // [1:0] status, [2] data_valid
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mqsa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mqsa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mqsa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mqsa_pkg::*;

   logic [CNT_W-1:0] queue_count_ff, queue_count_in;
   logic             csr_wr, cfg_wr;
   cmd_type          cmd;
   stat_type         stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_wr     = csr_wr && (csr_paddr == ADDR_QUEUE_COUNT);

   always_comb begin
      queue_count_in = queue_count_ff;
      if (cfg_wr) begin
         queue_count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_QUEUE_COUNT) begin
         csr_prdata = {{(CSR_DATA_W - CNT_W){1'b0}}, queue_count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_count_ff <= QUEUE_COUNT_RESET;
      end else begin
         queue_count_ff <= queue_count_in;
      end
   end

   mqsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cfg_wr     (cfg_wr),
      .stat       (stat),
      .cmd        (cmd)
   );

   mqsa_dp #(
      .ARRAY_SIZE (ARRAY_SIZE),
      .MAX_QUEUES (MAX_QUEUES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .queue_count (queue_count_ff),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

@@ rtl/mqsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on mqsa_pkg for its default sizes; used for the shared word store.
module mqsa_ram #(
   parameter int WIDTH = mqsa_pkg::DATA_W,
   parameter int DEPTH = mqsa_pkg::ARRAY_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mqsa_ctrl.sv @@
// Sequencing state machine for the shared-store queue block.
// Depends on mqsa_pkg for the command and status structs.
module mqsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               cfg_wr,
   input  mqsa_pkg::stat_type stat,
   output mqsa_pkg::cmd_type  cmd
);
   import mqsa_pkg::*;

`include "multi_queue_shared_array_top_assert.svh"

   typedef enum logic [12:0] {
      S_PART_INIT = 13'b0000000000001,
      S_PART      = 13'b0000000000010,
      S_IDLE      = 13'b0000000000100,
      S_CHK       = 13'b0000000001000,
      S_DEQ       = 13'b0000000010000,
      S_RDW       = 13'b0000000100000,
      S_RD1       = 13'b0000001000000,
      S_RD2       = 13'b0000010000000,
      S_ENQ       = 13'b0000100000000,
      S_SHIFT     = 13'b0001000000000,
      S_UPD1      = 13'b0010000000000,
      S_UPD2      = 13'b0100000000000,
      S_FIN       = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_PART_INIT: begin
            cmd.part_start = 1'b1;
            state_in       = S_PART;
         end
         S_PART: begin
            cmd.part_step = 1'b1;
            if (stat.part_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_CHK;
            end
         end
         S_CHK: begin
            cmd.res_clear = 1'b1;
            if (stat.ignored) begin
               state_in = S_FIN;
            end else if (stat.bad_q) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_BADQ;
               state_in     = S_FIN;
            end else begin
               cmd.rd_q = 1'b1;
               state_in = stat.is_enq ? S_RD1 : S_DEQ;
            end
         end
         S_DEQ: begin
            if (stat.empty) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_UNDER;
               state_in     = S_FIN;
            end else begin
               cmd.ram_rd_head = 1'b1;
               cmd.deq_upd     = 1'b1;
               state_in        = S_RDW;
            end
         end
         S_RDW: begin
            cmd.cap_data = 1'b1;
            state_in     = S_FIN;
         end
         S_RD1: begin
            cmd.rd_n1 = 1'b1;
            state_in  = S_RD2;
         end
         S_RD2: begin
            cmd.rd_n2 = 1'b1;
            state_in  = S_ENQ;
         end
         S_ENQ: begin
            if (!stat.full) begin
               cmd.enq_simple = 1'b1;
               state_in       = S_FIN;
            end else if (stat.can_borrow) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_OVER;
               state_in     = S_FIN;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = S_UPD1;
            end
         end
         S_UPD1: begin
            cmd.borrow_upd1 = 1'b1;
            state_in        = S_UPD2;
         end
         S_UPD2: begin
            cmd.borrow_upd2 = 1'b1;
            state_in        = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_PART_INIT;
         end
      endcase
      // A write of queue_count re-partitions the store from scratch.
      if (cfg_wr) begin
         state_in = S_PART_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_PART_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `MQSA_ASSERT_NXT(a_cfg_repartitions, clock, reset, cfg_wr, state_ff == S_PART_INIT, "register write did not restart partitioning")

endmodule

@@ rtl/mqsa_dp.sv @@
// Datapath of the shared-store queue block: queue bounds, partition sweep,
// shift engine, word store and result registers. Depends on mqsa_pkg and mqsa_ram.
module mqsa_dp #(
   parameter int ARRAY_SIZE = mqsa_pkg::ARRAY_SIZE_DEF,
   parameter int MAX_QUEUES = mqsa_pkg::MAX_QUEUES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mqsa_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  logic [mqsa_pkg::DATA_W-1:0]         req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mqsa_pkg::DATA_W-1:0]         rsp_tdata,
   output logic [mqsa_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input  logic [mqsa_pkg::CNT_W-1:0]          queue_count,
   input  mqsa_pkg::cmd_type                   cmd,
   output mqsa_pkg::stat_type                  stat
);
   import mqsa_pkg::*;

`include "multi_queue_shared_array_top_assert.svh"

   localparam int LIM = (MAX_QUEUES < ARRAY_SIZE) ? MAX_QUEUES : ARRAY_SIZE;
   localparam int KW  = $clog2(LIM + 1);
   localparam int IW  = $clog2(ARRAY_SIZE + 1) + 1;
   localparam int AW  = $clog2(ARRAY_SIZE);
   localparam int XW  = $clog2(MAX_QUEUES + 1);

   function automatic logic [XW-1:0] clamp_idx(input int v);
      logic [XW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > MAX_QUEUES) begin
         r = XW'(MAX_QUEUES);
      end else begin
         r = XW'(v);
      end
      return r;
   endfunction

   // Segment length for every possible queue count.
   logic signed [IW-1:0] seg_tab [LIM];
   for (genvar g = 0; g < LIM; g++) begin : g_seg
      localparam int SEG = ARRAY_SIZE / (g + 1);
      assign seg_tab[g] = IW'(SEG);
   end

   // Per-queue bounds; entry j describes queue j+1, boundary entry j is boundary[j+1].
   logic signed [IW-1:0] head_ff [MAX_QUEUES+1];
   logic signed [IW-1:0] tail_ff [MAX_QUEUES+1];
   logic signed [IW-1:0] bnd_ff  [MAX_QUEUES+1];

   logic [REQ_W-1:0]     req_ff, req_in;
   logic [QID_W-1:0]     qid_ff, qid_in;
   logic [DATA_W-1:0]    din_ff, din_in;
   logic [KW-1:0]        kq_ff, kq_in, kq_new;
   logic signed [IW-1:0] seg_ff, seg_in, seg_sel;
   logic signed [IW-1:0] start_ff, start_in;
   logic [XW-1:0]        pidx_ff, pidx_in;
   logic signed [IW-1:0] hq_ff, hq_in, tq_ff, tq_in;
   logic signed [IW-1:0] bn1_ff, bn1_in, tn1_ff, tn1_in, hn1_ff, hn1_in;
   logic signed [IW-1:0] bn2_ff, bn2_in;
   logic signed [IW-1:0] ptr_ff, ptr_in, ptr_inc, tq_inc;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   status_type           res_status_ff, res_status_in;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;
   logic                 res_dv_ff, res_dv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_dv_ff, rsp_dv_in;

   logic [XW-1:0]        qm1_idx, q0_idx, qp1_idx, rd_idx;
   logic                 ctx_we, head_we, tail_we, bnd_we;
   logic [XW-1:0]        ctx_idx;
   logic signed [IW-1:0] head_wd, tail_wd, bnd_wd;
   logic                 shift_rd;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [DATA_W-1:0]    ram_wdata, ram_rdata;

   always_comb begin
      int qc;
      qc = int'(queue_count);
      if (qc < 1) begin
         kq_new = KW'(1);
      end else if (qc > LIM) begin
         kq_new = KW'(LIM);
      end else begin
         kq_new = KW'(qc);
      end
      seg_sel = IW'(ARRAY_SIZE);
      for (int g = 0; g < LIM; g++) begin
         if (int'(kq_new) == g + 1) begin
            seg_sel = seg_tab[g];
         end
      end
   end

   assign qm1_idx = clamp_idx(int'(qid_ff) - 1);
   assign q0_idx  = clamp_idx(int'(qid_ff));
   assign qp1_idx = clamp_idx(int'(qid_ff) + 1);
   assign rd_idx  = cmd.rd_n2 ? qp1_idx : (cmd.rd_n1 ? q0_idx : qm1_idx);

   assign tq_inc  = tq_ff + IW'(1);
   assign ptr_inc = ptr_ff + IW'(1);

   always_comb begin
      stat.ignored    = !((req_ff == REQ_ENQ) || (req_ff == REQ_DEQ) || (req_ff == REQ_PEEK));
      stat.bad_q      = (qid_ff == '0) || (int'(qid_ff) > int'(kq_ff));
      stat.is_enq     = (req_ff == REQ_ENQ);
      stat.empty      = (tq_ff < hq_ff);
      stat.full       = (tq_ff == bn1_ff);
      stat.can_borrow = (int'(qid_ff) != int'(kq_ff)) && (tn1_ff != bn2_ff);
      stat.shift_done = (ptr_ff < hn1_ff);
      stat.part_done  = (int'(pidx_ff) == int'(kq_ff));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign shift_rd = cmd.shift_step && !stat.shift_done;

   always_comb begin
      req_in        = req_ff;
      qid_in        = qid_ff;
      din_in        = din_ff;
      kq_in         = kq_ff;
      seg_in        = seg_ff;
      start_in      = start_ff;
      pidx_in       = pidx_ff;
      hq_in         = hq_ff;
      tq_in         = tq_ff;
      bn1_in        = bn1_ff;
      tn1_in        = tn1_ff;
      hn1_in        = hn1_ff;
      bn2_in        = bn2_ff;
      ptr_in        = ptr_ff;
      wr_pend_in    = shift_rd;
      wr_addr_in    = ptr_inc[AW-1:0];
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_dv_in     = res_dv_ff;
      ctx_we        = 1'b0;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      bnd_we        = 1'b0;
      ctx_idx       = qm1_idx;
      head_wd       = hq_ff;
      tail_wd       = tq_inc;
      bnd_wd        = bn1_ff;

      if (cmd.latch_req) begin
         req_in = req_tuser[REQ_W-1:0];
         qid_in = req_tuser[REQ_W +: QID_W];
         din_in = req_tdata;
      end

      if (cmd.part_start) begin
         kq_in    = kq_new;
         seg_in   = seg_sel;
         start_in = -IW'(1);
         pidx_in  = '0;
      end

      // One queue per cycle; the final step closes the store at its top word.
      if (cmd.part_step) begin
         ctx_we  = 1'b1;
         ctx_idx = pidx_ff;
         bnd_we  = 1'b1;
         if (int'(pidx_ff) < int'(kq_ff)) begin
            head_we  = 1'b1;
            tail_we  = 1'b1;
            head_wd  = start_ff + IW'(1);
            tail_wd  = start_ff;
            bnd_wd   = start_ff;
            start_in = start_ff + seg_ff;
            pidx_in  = pidx_ff + XW'(1);
         end else begin
            bnd_wd = IW'(ARRAY_SIZE - 1);
         end
      end

      if (cmd.rd_q) begin
         hq_in = head_ff[rd_idx];
         tq_in = tail_ff[rd_idx];
      end
      if (cmd.rd_n1) begin
         bn1_in = bnd_ff[rd_idx];
         tn1_in = tail_ff[rd_idx];
         hn1_in = head_ff[rd_idx];
      end
      if (cmd.rd_n2) begin
         bn2_in = bnd_ff[rd_idx];
      end

      if (cmd.deq_upd && (req_ff == REQ_DEQ)) begin
         ctx_we  = 1'b1;
         head_we = 1'b1;
         head_wd = hq_ff + IW'(1);
      end

      if (cmd.enq_simple || cmd.borrow_upd2) begin
         ctx_we  = 1'b1;
         tail_we = 1'b1;
         tail_wd = tq_inc;
      end

      // The neighbour queue has moved up by one word, bounds and all.
      if (cmd.borrow_upd1) begin
         ctx_we  = 1'b1;
         ctx_idx = q0_idx;
         head_we = 1'b1;
         tail_we = 1'b1;
         bnd_we  = 1'b1;
         head_wd = hn1_ff + IW'(1);
         tail_wd = tn1_ff + IW'(1);
         bnd_wd  = bn1_ff + IW'(1);
      end

      if (cmd.shift_init) begin
         ptr_in = tn1_ff;
      end
      if (shift_rd) begin
         ptr_in = ptr_ff - IW'(1);
      end

      if (cmd.res_clear) begin
         res_status_in = ST_OK;
         res_data_in   = '0;
         res_dv_in     = 1'b0;
      end
      if (cmd.res_set) begin
         res_status_in = cmd.res_code;
      end
      if (cmd.cap_data) begin
         res_data_in = ram_rdata;
         res_dv_in   = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_dv_in     = rsp_dv_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_dv_in     = res_dv_ff;
      end
   end

   // The shift writes each word one slot up in the cycle after it was read.
   always_comb begin
      ram_re    = shift_rd || cmd.ram_rd_head;
      ram_raddr = cmd.ram_rd_head ? hq_ff[AW-1:0] : ptr_ff[AW-1:0];
      ram_we    = wr_pend_ff || cmd.enq_simple || cmd.borrow_upd1;
      ram_waddr = wr_pend_ff ? wr_addr_ff : tq_inc[AW-1:0];
      ram_wdata = wr_pend_ff ? ram_rdata : din_ff;
   end

   mqsa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ARRAY_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (ctx_we) begin
         if (head_we) begin
            head_ff[ctx_idx] <= head_wd;
         end
         if (tail_we) begin
            tail_ff[ctx_idx] <= tail_wd;
         end
         if (bnd_we) begin
            bnd_ff[ctx_idx] <= bnd_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pidx_ff      <= '0;
      end else begin
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         pidx_ff      <= pidx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      qid_ff        <= qid_in;
      din_ff        <= din_in;
      kq_ff         <= kq_in;
      seg_ff        <= seg_in;
      start_ff      <= start_in;
      hq_ff         <= hq_in;
      tq_ff         <= tq_in;
      bn1_ff        <= bn1_in;
      tn1_ff        <= tn1_in;
      hn1_ff        <= hn1_in;
      bn2_ff        <= bn2_in;
      ptr_ff        <= ptr_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_dv_ff     <= res_dv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dv_ff     <= rsp_dv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_dv_ff, rsp_status_ff};

   `MQSA_ASSERT_IMP(a_load_needs_room, clock, reset, cmd.out_load, stat.out_free, "result loaded over an untaken item")
   `MQSA_ASSERT_IMP(a_shift_in_bounds, clock, reset, shift_rd, ptr_ff < bn2_ff, "shift would write past the neighbour queue")
   `MQSA_ASSERT_IMP(a_simple_not_full, clock, reset, cmd.enq_simple, tq_ff != bn1_ff, "plain enqueue into a full segment")

endmodule

@@ tb/sv/tb_multi_queue_shared_array_top.sv @@
// Self-checking testbench for the shared-store multi-queue block.
// Drives the req stream, the csr register port and a stalling rsp receiver, and predicts
// every result with a scoreboard class. Depends on mqsa_pkg and multi_queue_shared_array_top.
module tb_multi_queue_shared_array_top;
   import mqsa_pkg::*;

   localparam int STORE_WORDS = ARRAY_SIZE_DEF;
   localparam int QUEUE_LIMIT = MAX_QUEUES_DEF;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   // Longest borrowing enqueue plus some margin.
   localparam int DRAIN_CYCLES = STORE_WORDS + 16;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;   // [31:0] data_in
   logic [REQ_TUSER_W-1:0] req_tuser;   // [1:0] req_type, [5:2] queue_id
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [DATA_W-1:0]      rsp_tdata;   // [31:0] data_out
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [1:0] status, [2] data_valid
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] data_out;
      logic              data_valid;
   } reply_type;

   class queue_store_scoreboard;
      logic [DATA_W-1:0] words [STORE_WORDS];
      int        head_pos [QUEUE_LIMIT + 2];
      int        tail_pos [QUEUE_LIMIT + 2];
      int        bound [QUEUE_LIMIT + 3];
      int        kq;
      reply_type pending_replies[$];
      int        mismatches;
      int        checked;
      int        requests;
      int        borrows;
      int        overflows;
      int        underflows;
      int        bad_ids;
      int        ignored;

      function new();
         mismatches = 0;
         checked    = 0;
         requests   = 0;
         borrows    = 0;
         overflows  = 0;
         underflows = 0;
         bad_ids    = 0;
         ignored    = 0;
         set_queue_count(QUEUE_COUNT_RESET);
      endfunction

      // Re-cut the store into segments of equal length, the last taking any remainder; every queue starts empty.
      function void set_queue_count(logic [CNT_W-1:0] value);
         int seg;
         int limit;
         limit = (QUEUE_LIMIT < STORE_WORDS) ? QUEUE_LIMIT : STORE_WORDS;
         if (value < 1) kq = 1;
         else if (value > limit) kq = limit;
         else kq = value;
         seg = STORE_WORDS / kq;
         for (int q = 1; q <= kq; q++) begin
            head_pos[q] = seg * (q - 1);
            tail_pos[q] = seg * (q - 1) - 1;
            bound[q]    = seg * (q - 1) - 1;
         end
         bound[kq + 1] = STORE_WORDS - 1;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [QID_W-1:0] qid,
                                 logic [DATA_W-1:0] word);
         reply_type want;
         int        q;
         want.status     = ST_OK;
         want.data_out   = '0;
         want.data_valid = 1'b0;
         requests++;
         if (kind == REQ_UNUSED) begin
            ignored++;
         end else if (qid < 1 || qid > kq) begin
            want.status = ST_BADQ;
            bad_ids++;
         end else begin
            q = qid;
            if (kind == REQ_ENQ) begin
               if (tail_pos[q] == bound[q + 1]) begin
                  // A full segment takes one slot from the next queue if that one has room.
                  if (q != kq && tail_pos[q + 1] != bound[q + 2]) begin
                     for (int i = tail_pos[q + 1]; i >= head_pos[q + 1]; i--)
                        words[i + 1] = words[i];
                     bound[q + 1]++;
                     tail_pos[q + 1]++;
                     head_pos[q + 1]++;
                     tail_pos[q]++;
                     words[tail_pos[q]] = word;
                     borrows++;
                  end else begin
                     want.status = ST_OVER;
                     overflows++;
                  end
               end else begin
                  tail_pos[q]++;
                  words[tail_pos[q]] = word;
               end
            end else if (tail_pos[q] < head_pos[q]) begin
               want.status = ST_UNDER;
               underflows++;
            end else begin
               want.data_out   = words[head_pos[q]];
               want.data_valid = 1'b1;
               if (kind == REQ_DEQ) head_pos[q]++;
            end
         end
         pending_replies.push_back(want);
      endfunction

      function void check_reply(logic [DATA_W-1:0] tdata, logic [RSP_TUSER_W-1:0] tuser);
         reply_type want;
         checked++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result with no request outstanding: status %0d data %h valid %0b",
                        $time, tuser[1:0], tdata, tuser[2]);
            return;
         end
         want = pending_replies.pop_front();
         if (tuser[1:0] !== want.status || tuser[2] !== want.data_valid ||
             tdata !== want.data_out) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result %0d: expected status %0d data %h valid %0b, got status %0d data %h valid %0b",
                        $time, checked, want.status, want.data_out, want.data_valid,
                        tuser[1:0], tdata, tuser[2]);
         end
      endfunction
   endclass

   queue_store_scoreboard sb;
   int burst_left;
   int settings_done;

   multi_queue_shared_array_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Offers one item, with a random gap between bursts, and notes it once accepted.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [QID_W-1:0] qid,
                               input logic [DATA_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= {qid, kind};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, qid, word);
   endtask

   // Holds off the sender until every outstanding result has been delivered.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_queue_count(input logic [CNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_QUEUE_COUNT;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_queue_count(value);
      settings_done++;
   endtask

   // Mostly well-formed requests aimed at a hot queue, with some unused codes and bad ids.
   // Unused codes are not counted towards n.
   task automatic send_random(input int n, input int enq_pct);
      int               done;
      int               hot;
      int               pick;
      logic [REQ_W-1:0] kind;
      logic [QID_W-1:0] qid;
      done = 0;
      hot  = $urandom_range(sb.kq, 1);
      while (done < n) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            kind = REQ_UNUSED;
            qid  = QID_W'($urandom);
         end else begin
            done++;
            if (pick < 8)
               qid = ($urandom_range(1) == 0) ? '0 : QID_W'($urandom_range(15, sb.kq + 1));
            else if ($urandom_range(99) < 60)
               qid = QID_W'(hot);
            else
               qid = QID_W'($urandom_range(sb.kq, 1));
            if ($urandom_range(99) < enq_pct) kind = REQ_ENQ;
            else kind = ($urandom_range(1) == 1) ? REQ_DEQ : REQ_PEEK;
         end
         send_request(kind, qid, random_word());
      end
   endtask

   initial begin
      int count_plan [10];
      count_plan  = '{1, 2, 8, 0, 5, 15, 3, 7, 4, 6};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 0;
      settings_done = 0;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Queue four does not exist with the reset count of three.
      send_request(REQ_ENQ, 4'd4, 32'h1234_5678);
      wait_idle();
      write_queue_count(4'd8);
      send_request(REQ_PEEK, 4'd1, 32'h0);
      send_request(REQ_DEQ, 4'd1, 32'hFFFF_FFFF);
      send_request(REQ_ENQ, 4'd2, 32'h8000_0000);
      send_request(REQ_ENQ, 4'd2, 32'h7FFF_FFFF);
      // Eight words fill queue one; the ninth borrows a slot and shifts queue two up.
      for (int i = 0; i < 9; i++)
         send_request(REQ_ENQ, 4'd1, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
      send_request(REQ_PEEK, 4'd1, 32'h0);
      send_request(REQ_DEQ, 4'd1, 32'h0);
      send_request(REQ_PEEK, 4'd2, 32'h0);
      send_request(REQ_ENQ, 4'd0, 32'hFFFF_FFFF);
      send_request(REQ_PEEK, 4'd15, 32'h0);
      send_request(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF);
      wait_idle();
      // A count above the limit acts as eight; the last queue cannot borrow.
      write_queue_count(4'd15);
      for (int i = 0; i < 9; i++)
         send_request(REQ_ENQ, 4'd8, $urandom);

      foreach (count_plan[p]) begin
         wait_idle();
         write_queue_count(CNT_W'(count_plan[p]));
         send_random(70, 95);
         wait_idle();
         send_random(25, 40);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d queue-count settings: %0d borrows, %0d overflows,",
               sb.requests, settings_done, sb.borrows, sb.overflows);
      $display("%0d underflows, %0d bad queue numbers, %0d unused codes; %0d results checked.",
               sb.underflows, sb.bad_ids, sb.ignored, sb.checked);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: checks each result taken and stalls in one of three randomly chosen patterns.
   initial begin
      int stall_mode;
      int cycle;
      rsp_tready = 1'b0;
      stall_mode = 0;
      cycle      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata, rsp_tuser);
         if (cycle % 40 == 0) stall_mode = $urandom_range(2);
         cycle++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(1) == 1);
            default: rsp_tready <= ($urandom_range(5) == 0);
         endcase
      end
   end

   initial begin
      #6000000;
      $display("Timeout: the run did not complete.");
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mqsa_pkg.sv
rtl/mqsa_ram.sv
rtl/mqsa_ctrl.sv
rtl/mqsa_dp.sv
rtl/multi_queue_shared_array_top.sv
tb/sv/tb_multi_queue_shared_array_top.sv
